FILE: hdl/csc_pkg.sv
// Shared widths, reset values, key codes and register indexes for the clock and stepper controller.
package csc_pkg;

  localparam int DivW   = 10;
  localparam int StepW  = 8;
  localparam int TpsW   = 8;
  localparam int KeyW   = 8;
  localparam int CoilW  = 8;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int FieldW = 2;
  localparam int PhaseW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 10;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinDivisor     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxDivisor     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDivisorStep    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 2'd3;

  // Configuration reset values
  localparam logic [DivW-1:0]  MinDivisorRst     = 10'd120;
  localparam logic [DivW-1:0]  MaxDivisorRst     = 10'd300;
  localparam logic [StepW-1:0] DivisorStepRst    = 8'd10;
  localparam logic [TpsW-1:0]  TicksPerSecondRst = 8'd50;

  // State reset values
  localparam logic [CoilW-1:0] CoilRst    = 8'hFF;
  localparam logic [DivW-1:0]  DivisorRst = 10'd220;

  // Active-low key codes
  localparam logic [KeyW-1:0] KeyIdle   = 8'hFF;
  localparam logic [KeyW-1:0] KeyFaster = 8'hFE;
  localparam logic [KeyW-1:0] KeySlower = 8'hFD;
  localparam logic [KeyW-1:0] KeyMode   = 8'hFB;
  localparam logic [KeyW-1:0] KeyPage   = 8'hF7;

  // Selectable time fields
  localparam logic [FieldW-1:0] FieldHours   = 2'd0;
  localparam logic [FieldW-1:0] FieldMinutes = 2'd1;
  localparam logic [FieldW-1:0] FieldSeconds = 2'd2;

  // Clock limits
  localparam logic [MinW:0] HoursPerDay  = 7'd24;
  localparam logic [MinW:0] MinsPerHour  = 7'd60;
  localparam logic [MinW:0] SecsPerMin   = 7'd60;

  // Command codes
  localparam logic CmdMotor   = 1'b0;
  localparam logic CmdControl = 1'b1;

endpackage

FILE: hdl/clock_and_stepper_controller_unit.sv
// Clock and stepper controller: motor phase sequencing, time keeping and key handling.
//
// Each accepted item is one tick. A motor tick (cmd 0) advances two four-phase
// steppers whose one-hot phases share coil_drive: the low nibble steps once every
// speed_divisor motor ticks, the high nibble once every speed_divisor fast steps
// (a divisor of zero steps on every tick). A control tick (cmd 1) counts toward
// one second of the hh:mm:ss clock
// while the display page is shown, and samples the active-low keys: an action is
// taken only when the previous sample had all keys released and the new one is
// exactly one of the four known key codes. Every item yields exactly one result
// that shows the state after that tick, including its clear_display flag. The
// whole update is one pass of counter, add and compare logic from the state
// registers into themselves, so an item is accepted every cycle as long as the
// result slot is empty or being drained in the same cycle; in_ready follows
// out_ready combinationally. Configuration writes take effect at once and are
// ignored while rst is high; write them only while no item is in flight.
module clock_and_stepper_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [csc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [csc_pkg::CfgDataW-1:0]  cfg_data,
  // tick input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [csc_pkg::KeyW-1:0]      key_sample,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csc_pkg::CoilW-1:0]     coil_drive,
  output logic [csc_pkg::HourW-1:0]     hours,
  output logic [csc_pkg::MinW-1:0]      minutes,
  output logic [csc_pkg::SecW-1:0]      seconds,
  output logic [csc_pkg::DivW-1:0]      speed_divisor,
  output logic                          settings_page,
  output logic                          adjust_mode,
  output logic [csc_pkg::FieldW-1:0]    selected_field,
  output logic                          motor_enabled,
  output logic                          clear_display
);
  import csc_pkg::*;

  // configuration registers
  logic [DivW-1:0]  min_divisor;
  logic [DivW-1:0]  max_divisor;
  logic [StepW-1:0] divisor_step;
  logic [TpsW-1:0]  ticks_per_second;

  // state registers; the visible ones drive the result ports directly
  logic [CoilW-1:0]  coil_latch,      coil_latch_next;
  logic [PhaseW-1:0] fast_phase,      fast_phase_next;
  logic [PhaseW-1:0] slow_phase,      slow_phase_next;
  logic [DivW-1:0]   fast_count,      fast_count_next;
  logic [DivW-1:0]   slow_count,      slow_count_next;
  logic [DivW-1:0]   divisor_reg,     divisor_reg_next;
  logic [TpsW-1:0]   subsecond_count, subsecond_count_next;
  logic [HourW-1:0]  hour_reg,        hour_reg_next;
  logic [MinW-1:0]   minute_reg,      minute_reg_next;
  logic [SecW-1:0]   second_reg,      second_reg_next;
  logic [KeyW-1:0]   previous_keys,   previous_keys_next;
  logic              page_flag,       page_flag_next;
  logic              mode_flag,       mode_flag_next;
  logic [FieldW-1:0] field_select,    field_select_next;
  logic              enable_flag,     enable_flag_next;
  logic              clear_reg,       clear_next;
  logic              out_valid_reg;

  logic in_accept;

  // motor path
  logic              fast_hit, slow_hit;
  logic [DivW-1:0]   fast_after, slow_after;

  // clock path
  logic [TpsW-1:0]   sub_inc;
  logic              sec_tick;
  logic [MinW:0]     sec_inc, min_inc, hour_inc;
  logic              sec_carry, min_carry;

  // key path
  logic              key_edge;
  logic [DivW:0]     div_minus, div_plus;
  logic [MinW:0]     field_cur, field_lim, field_inc, field_adj;
  logic              field_clr;

  assign in_ready  = !rst && (!out_valid_reg || out_ready);
  assign in_accept = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_divisor      <= MinDivisorRst;
      max_divisor      <= MaxDivisorRst;
      divisor_step     <= DivisorStepRst;
      ticks_per_second <= TicksPerSecondRst;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgMinDivisor:     min_divisor      <= cfg_data;
        CfgMaxDivisor:     max_divisor      <= cfg_data;
        CfgDivisorStep:    divisor_step     <= cfg_data[StepW-1:0];
        CfgTicksPerSecond: ticks_per_second <= cfg_data[TpsW-1:0];
        default: ;
      endcase
    end
  end

  // Motor step: fast stepper first, its step may feed the slow counter
  always_comb begin
    fast_hit   = fast_count >= divisor_reg;
    fast_after = fast_hit ? '0 : fast_count;
    slow_after = fast_hit ? slow_count + 1'b1 : slow_count;
    slow_hit   = slow_after >= divisor_reg;
  end

  // Clock advance: values stay in range, so one carry per digit suffices
  always_comb begin
    sub_inc   = subsecond_count + 1'b1;
    sec_tick  = !page_flag && (sub_inc >= ticks_per_second);
    sec_inc   = {1'b0, second_reg} + 1'b1;
    sec_carry = sec_inc >= SecsPerMin;
    min_inc   = {1'b0, minute_reg} + {{MinW{1'b0}}, sec_carry};
    min_carry = min_inc >= MinsPerHour;
    hour_inc  = {2'b0, hour_reg} + {{MinW{1'b0}}, min_carry};
  end

  // Key actions
  always_comb begin
    key_edge  = (key_sample != previous_keys) && (previous_keys == KeyIdle);
    div_minus = {1'b0, divisor_reg} - {{(DivW+1-StepW){1'b0}}, divisor_step};
    div_plus  = {1'b0, divisor_reg} + {{(DivW+1-StepW){1'b0}}, divisor_step};

    case (field_select)
      FieldHours:   field_cur = {2'b0, hour_reg};
      FieldMinutes: field_cur = {1'b0, minute_reg};
      default:      field_cur = {1'b0, second_reg};
    endcase
    field_lim = (field_select == FieldHours) ? HoursPerDay : MinsPerHour;
    field_inc = field_cur + 1'b1;
    field_adj = field_cur;
    field_clr = 1'b0;
    if (key_sample == KeyFaster) begin
      if (field_inc >= field_lim) begin
        field_adj = field_inc - field_lim;
        field_clr = 1'b1;
      end else begin
        field_adj = field_inc;
      end
    end else begin
      if (field_cur == '0) begin
        field_adj = field_lim - 1'b1;
      end else begin
        field_adj = field_cur - 1'b1;
        field_clr = field_cur == 7'd10;
      end
    end
  end

  // Next state for one tick
  always_comb begin
    coil_latch_next      = coil_latch;
    fast_phase_next      = fast_phase;
    slow_phase_next      = slow_phase;
    fast_count_next      = fast_count;
    slow_count_next      = slow_count;
    divisor_reg_next     = divisor_reg;
    subsecond_count_next = subsecond_count;
    hour_reg_next        = hour_reg;
    minute_reg_next      = minute_reg;
    second_reg_next      = second_reg;
    previous_keys_next   = previous_keys;
    page_flag_next       = page_flag;
    mode_flag_next       = mode_flag;
    field_select_next    = field_select;
    enable_flag_next     = enable_flag;
    clear_next           = 1'b0;

    if (cmd == CmdMotor) begin
      // hold everything while the motors are disabled
      if (enable_flag) begin
        if (fast_hit) begin
          coil_latch_next[3:0] = 4'b0001 << fast_phase;
          fast_phase_next      = fast_phase + 1'b1;
        end
        if (slow_hit) begin
          coil_latch_next[7:4] = 4'b0001 << slow_phase;
          slow_phase_next      = slow_phase + 1'b1;
        end
        slow_count_next = slow_hit ? '0 : slow_after;
        fast_count_next = fast_after + 1'b1;
      end
    end else begin
      if (!page_flag) begin
        subsecond_count_next = sub_inc;
        if (sec_tick) begin
          subsecond_count_next = '0;
          second_reg_next = sec_carry ? '0 : sec_inc[SecW-1:0];
          minute_reg_next = min_carry ? '0 : min_inc[MinW-1:0];
          hour_reg_next   = (hour_inc >= HoursPerDay) ? '0 : hour_inc[HourW-1:0];
          clear_next      = sec_carry;
        end
      end

      if (key_sample != previous_keys) begin
        previous_keys_next = key_sample;
      end

      if (key_edge) begin
        case (key_sample)
          KeyFaster, KeySlower: begin
            if (!page_flag) begin
              // speed keys clamp at the configured limits
              if (key_sample == KeyFaster) begin
                if (div_minus[DivW] || (div_minus[DivW-1:0] <= min_divisor)) begin
                  divisor_reg_next = min_divisor;
                end else begin
                  divisor_reg_next = div_minus[DivW-1:0];
                end
              end else begin
                if (div_plus >= {1'b0, max_divisor}) begin
                  divisor_reg_next = max_divisor;
                end else begin
                  divisor_reg_next = div_plus[DivW-1:0];
                end
              end
            end else if (!mode_flag) begin
              // move the selection between hours, minutes and seconds
              if (key_sample == KeyFaster) begin
                field_select_next = (field_select == FieldHours) ? FieldSeconds
                                                                 : field_select - 1'b1;
              end else begin
                field_select_next = (field_select >= FieldSeconds) ? FieldHours
                                                                   : field_select + 1'b1;
              end
            end else begin
              case (field_select)
                FieldHours:   hour_reg_next   = field_adj[HourW-1:0];
                FieldMinutes: minute_reg_next = field_adj[MinW-1:0];
                default:      second_reg_next = field_adj[SecW-1:0];
              endcase
              clear_next = clear_next | field_clr;
            end
          end
          KeyMode: mode_flag_next = !mode_flag;
          KeyPage: begin
            page_flag_next   = !page_flag;
            enable_flag_next = !enable_flag;
            clear_next       = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // State and result registers advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_latch      <= CoilRst;
      fast_phase      <= '0;
      slow_phase      <= '0;
      fast_count      <= '0;
      slow_count      <= '0;
      divisor_reg     <= DivisorRst;
      subsecond_count <= '0;
      hour_reg        <= '0;
      minute_reg      <= '0;
      second_reg      <= '0;
      previous_keys   <= KeyIdle;
      page_flag       <= 1'b0;
      mode_flag       <= 1'b0;
      field_select    <= FieldSeconds;
      enable_flag     <= 1'b1;
      clear_reg       <= 1'b0;
      out_valid_reg   <= 1'b0;
    end else begin
      if (in_accept) begin
        coil_latch      <= coil_latch_next;
        fast_phase      <= fast_phase_next;
        slow_phase      <= slow_phase_next;
        fast_count      <= fast_count_next;
        slow_count      <= slow_count_next;
        divisor_reg     <= divisor_reg_next;
        subsecond_count <= subsecond_count_next;
        hour_reg        <= hour_reg_next;
        minute_reg      <= minute_reg_next;
        second_reg      <= second_reg_next;
        previous_keys   <= previous_keys_next;
        page_flag       <= page_flag_next;
        mode_flag       <= mode_flag_next;
        field_select    <= field_select_next;
        enable_flag     <= enable_flag_next;
        clear_reg       <= clear_next;
        out_valid_reg   <= 1'b1;
      end else if (out_ready) begin
        // drop the result once taken
        out_valid_reg <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_reg;
  assign coil_drive     = coil_latch;
  assign hours          = hour_reg;
  assign minutes        = minute_reg;
  assign seconds        = second_reg;
  assign speed_divisor  = divisor_reg;
  assign settings_page  = page_flag;
  assign adjust_mode    = mode_flag;
  assign selected_field = field_select;
  assign motor_enabled  = enable_flag;
  assign clear_display  = clear_reg;

endmodule

FILE: hdl/csc_checker.sv
// Port-level checks for the clock and stepper controller, bound to the top level.
module csc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         cmd,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [csc_pkg::HourW-1:0]    hours,
  input logic [csc_pkg::MinW-1:0]     minutes,
  input logic [csc_pkg::SecW-1:0]     seconds,
  input logic [csc_pkg::FieldW-1:0]   selected_field,
  input logic                         clear_display
);
  import csc_pkg::*;

  // A result waiting to be taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Every accepted tick produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // A motor tick never asks for a clear and never moves the clock
  a_motor_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CmdMotor)
      |=> !clear_display && $stable(hours) && $stable(minutes) && $stable(seconds))
    else $error("motor tick disturbed the clock or display");

  // Time fields and selection stay within their ranges
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hours < 5'd24) && (minutes < 6'd60) && (seconds < 6'd60)
                  && (selected_field != 2'd3))
    else $error("time field or selection out of range");

endmodule

bind clock_and_stepper_controller_unit csc_checker u_csc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .cmd            (cmd),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .hours          (hours),
  .minutes        (minutes),
  .seconds        (seconds),
  .selected_field (selected_field),
  .clear_display  (clear_display)
);
